@@ src/q8bsm_pkg.sv @@
// ----------------------------------------------------------------------------
// q8bsm_pkg
// Shared widths, register indexes and the command/status bundles that join
// the controller and the datapath of the block-scaled matvec core.
// ----------------------------------------------------------------------------
package q8bsm_pkg;

  // Lane count and field widths
  localparam int LANES      = 4;
  localparam int LANE_W     = $clog2(LANES);
  localparam int WEIGHT_W   = 8;
  localparam int ACT_W      = 32;
  localparam int SCALE_W    = 16;
  localparam int CFG_W      = 16;
  localparam int ACC_W      = 64;
  localparam int RESULT_W   = 32;

  // Scale multiply: the block sum is split into two 28-bit halves
  localparam int HALF_W     = 28;
  localparam int PART_W     = HALF_W + 1 + SCALE_W;   // signed partial product
  localparam int SUM56_W    = 2 * HALF_W;             // bits that survive << 8

  // Configuration register indexes
  localparam logic CFG_ROW_LENGTH = 1'b0;
  localparam logic CFG_ROW_COUNT  = 1'b1;

  // Reset values of the configuration registers
  localparam logic [CFG_W-1:0] ROW_LENGTH_RST = 16'd32;
  localparam logic [CFG_W-1:0] ROW_COUNT_RST  = 16'd1;

  typedef logic signed [WEIGHT_W-1:0] weight_t;
  typedef logic signed [ACT_W-1:0]    act_t;

  // Controller to datapath
  typedef struct packed {
    logic              capture;    // latch a new request
    logic              lane_step;  // accumulate one lane, advance column
    logic [LANE_W-1:0] lane_sel;
    logic              mul_lo;     // scale times low half of block sum
    logic              mul_hi;     // scale times high half of block sum
    logic              flush_add;  // add scaled block into row sum, clear block
    logic              emit;       // load result, close the row
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic ended;     // column already at or past the row length
    logic blk_end;   // next column closes a block
    logic last_col;  // next column reaches the row length
    logic out_free;  // result register can take a new result
  } status_t;

endpackage

@@ src/q8bsm_ctrl.sv @@
// ----------------------------------------------------------------------------
// q8bsm_ctrl
// Sequencer: walks the lanes of one request, runs the three-step block
// flush when a block or a row closes, and issues the result at row end.
// ----------------------------------------------------------------------------
module q8bsm_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  q8bsm_pkg::status_t  status,
  output q8bsm_pkg::cmd_t     cmd
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_LANE   = 3'd1;
  localparam logic [2:0] S_MUL_LO = 3'd2;
  localparam logic [2:0] S_MUL_HI = 3'd3;
  localparam logic [2:0] S_ADD    = 3'd4;
  localparam logic [2:0] S_EMIT   = 3'd5;

  logic [2:0]                     state_r, state_nxt;
  logic [q8bsm_pkg::LANE_W-1:0]   lane_r, lane_nxt;
  logic                           final_r, final_nxt;
  logic                           last_lane;

  assign last_lane = (lane_r == q8bsm_pkg::LANE_W'(q8bsm_pkg::LANES - 1));
  assign in_stall  = (state_r != S_IDLE);

  // Next state and commands
  always_comb begin
    state_nxt     = state_r;
    lane_nxt      = lane_r;
    final_nxt     = final_r;
    cmd           = '0;
    cmd.lane_sel  = lane_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          lane_nxt    = '0;
          final_nxt   = 1'b0;
          state_nxt   = S_LANE;
        end
      end
      S_LANE: begin
        if (status.ended) begin
          final_nxt = 1'b1;
          state_nxt = S_MUL_LO;
        end else begin
          cmd.lane_step = 1'b1;
          if (status.blk_end || status.last_col) begin
            final_nxt = status.last_col;
            state_nxt = S_MUL_LO;
          end else if (last_lane) begin
            state_nxt = S_IDLE;
          end else begin
            lane_nxt = lane_r + 1'b1;
          end
        end
      end
      S_MUL_LO: begin
        cmd.mul_lo = 1'b1;
        state_nxt  = S_MUL_HI;
      end
      S_MUL_HI: begin
        cmd.mul_hi = 1'b1;
        state_nxt  = S_ADD;
      end
      S_ADD: begin
        cmd.flush_add = 1'b1;
        if (final_r) begin
          state_nxt = S_EMIT;
        end else if (last_lane) begin
          state_nxt = S_IDLE;
        end else begin
          lane_nxt  = lane_r + 1'b1;
          state_nxt = S_LANE;
        end
      end
      S_EMIT: begin
        // hold until the result register is free
        if (status.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      lane_r  <= '0;
      final_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      lane_r  <= lane_nxt;
      final_r <= final_nxt;
    end
  end

endmodule

@@ src/q8bsm_dp.sv @@
// ----------------------------------------------------------------------------
// q8bsm_dp
// Datapath: configuration registers, request capture, lane multiply and
// block sum, split scale multiply, row sum, row counters and result register.
// ----------------------------------------------------------------------------
module q8bsm_dp #(
  parameter int BLOCK_SIZE = 32
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_wr_en,
  input  logic                                cfg_index,
  input  logic [q8bsm_pkg::CFG_W-1:0]         cfg_data,
  input  logic signed [q8bsm_pkg::WEIGHT_W-1:0] in_weight_0,
  input  logic signed [q8bsm_pkg::WEIGHT_W-1:0] in_weight_1,
  input  logic signed [q8bsm_pkg::WEIGHT_W-1:0] in_weight_2,
  input  logic signed [q8bsm_pkg::WEIGHT_W-1:0] in_weight_3,
  input  logic signed [q8bsm_pkg::ACT_W-1:0]    in_activation_0,
  input  logic signed [q8bsm_pkg::ACT_W-1:0]    in_activation_1,
  input  logic signed [q8bsm_pkg::ACT_W-1:0]    in_activation_2,
  input  logic signed [q8bsm_pkg::ACT_W-1:0]    in_activation_3,
  input  logic signed [q8bsm_pkg::SCALE_W-1:0]  in_block_scale,
  input  q8bsm_pkg::cmd_t                     cmd,
  output q8bsm_pkg::status_t                  status,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [q8bsm_pkg::RESULT_W-1:0] out_row_result,
  output logic                                out_final_row
);

  localparam int BLK_W = (BLOCK_SIZE > 1) ? $clog2(BLOCK_SIZE) : 1;
  localparam int CW    = q8bsm_pkg::CFG_W;
  localparam int AW    = q8bsm_pkg::ACC_W;
  localparam int PW    = q8bsm_pkg::PART_W;
  localparam int HW    = q8bsm_pkg::HALF_W;
  localparam int SW    = q8bsm_pkg::SUM56_W;
  localparam int LPW   = q8bsm_pkg::WEIGHT_W + q8bsm_pkg::ACT_W;

  logic [CW-1:0]               row_len_r, row_cnt_r;
  q8bsm_pkg::weight_t          weight_r [q8bsm_pkg::LANES];
  q8bsm_pkg::act_t             act_r    [q8bsm_pkg::LANES];
  logic signed [q8bsm_pkg::SCALE_W-1:0] scale_r;

  logic [CW-1:0]               col_r, col_nxt;
  logic [BLK_W-1:0]            blk_pos_r, blk_pos_nxt;
  logic [CW-1:0]               row_pos_r, row_pos_nxt;
  logic [AW-1:0]               blk_acc_r, blk_acc_nxt;
  logic [AW-1:0]               row_acc_r, row_acc_nxt;
  logic signed [PW-1:0]        plo_r, phi_r;

  logic                        out_valid_r, out_valid_nxt;
  logic [q8bsm_pkg::RESULT_W-1:0] result_r;
  logic                        final_row_r;

  logic [CW-1:0]               len_eff, cnt_eff;
  logic [CW:0]                 col_inc, row_inc;
  logic                        row_done;
  logic signed [LPW-1:0]       lane_prod;
  logic signed [HW:0]          mul_a;
  logic signed [PW-1:0]        mul_p;
  logic [SW-1:0]               sum56;
  logic [AW-1:0]               scaled;

  // Zero length or count acts as one
  assign len_eff = (row_len_r == '0) ? CW'(1) : row_len_r;
  assign cnt_eff = (row_cnt_r == '0) ? CW'(1) : row_cnt_r;
  assign col_inc = {1'b0, col_r} + (CW+1)'(1);
  assign row_inc = {1'b0, row_pos_r} + (CW+1)'(1);
  assign row_done = (row_inc >= {1'b0, cnt_eff});

  assign status.ended    = (col_r >= len_eff);
  assign status.blk_end  = (blk_pos_r == BLK_W'(BLOCK_SIZE - 1));
  assign status.last_col = (col_inc >= {1'b0, len_eff});
  assign status.out_free = !out_valid_r || !out_stall;

  // Lane product of the selected lane
  assign lane_prod = weight_r[cmd.lane_sel] * act_r[cmd.lane_sel];

  // Shared scale multiplier: one half of the block sum per cycle
  assign mul_a = cmd.mul_hi ? {1'b0, blk_acc_r[2*HW-1:HW]} : {1'b0, blk_acc_r[HW-1:0]};
  assign mul_p = PW'(mul_a * scale_r);

  // Combine halves mod 2^56, then (x << 8) >>> 7 as a 64-bit word
  assign sum56  = SW'({{(SW-PW){plo_r[PW-1]}}, plo_r}) + {phi_r[HW-1:0], {HW{1'b0}}};
  assign scaled = {{(AW-SW-1){sum56[SW-1]}}, sum56, 1'b0};

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_len_r <= q8bsm_pkg::ROW_LENGTH_RST;
      row_cnt_r <= q8bsm_pkg::ROW_COUNT_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        q8bsm_pkg::CFG_ROW_LENGTH: row_len_r <= cfg_data;
        q8bsm_pkg::CFG_ROW_COUNT:  row_cnt_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Capture the request payload
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      weight_r[0] <= in_weight_0;
      weight_r[1] <= in_weight_1;
      weight_r[2] <= in_weight_2;
      weight_r[3] <= in_weight_3;
      act_r[0]    <= in_activation_0;
      act_r[1]    <= in_activation_1;
      act_r[2]    <= in_activation_2;
      act_r[3]    <= in_activation_3;
      scale_r     <= in_block_scale;
    end
  end

  // Partial products of the scale multiply
  always_ff @(posedge clk) begin
    if (cmd.mul_lo) begin
      plo_r <= mul_p;
    end
    if (cmd.mul_hi) begin
      phi_r <= mul_p;
    end
  end

  // Accumulators and position counters
  always_comb begin
    col_nxt     = col_r;
    blk_pos_nxt = blk_pos_r;
    row_pos_nxt = row_pos_r;
    blk_acc_nxt = blk_acc_r;
    row_acc_nxt = row_acc_r;
    if (cmd.lane_step) begin
      blk_acc_nxt = blk_acc_r + AW'(lane_prod);
      col_nxt     = col_inc[CW-1:0];
      blk_pos_nxt = status.blk_end ? '0 : blk_pos_r + 1'b1;
    end
    if (cmd.flush_add) begin
      row_acc_nxt = row_acc_r + scaled;
      blk_acc_nxt = '0;
    end
    if (cmd.emit) begin
      row_acc_nxt = '0;
      col_nxt     = '0;
      blk_pos_nxt = '0;
      row_pos_nxt = row_done ? '0 : row_inc[CW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r     <= '0;
      blk_pos_r <= '0;
      row_pos_r <= '0;
      blk_acc_r <= '0;
      row_acc_r <= '0;
    end else begin
      col_r     <= col_nxt;
      blk_pos_r <= blk_pos_nxt;
      row_pos_r <= row_pos_nxt;
      blk_acc_r <= blk_acc_nxt;
      row_acc_r <= row_acc_nxt;
    end
  end

  // Result register: load on emit, drop when taken
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (cmd.emit) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      result_r    <= row_acc_r[47:16];
      final_row_r <= row_done;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_row_result = result_r;
  assign out_final_row  = final_row_r;

endmodule

@@ src/q8_block_scaled_matvec_core.sv @@
// ----------------------------------------------------------------------------
// q8_block_scaled_matvec_core
// Block-scaled 8-bit quantized matrix-vector product, four lanes per request.
// ----------------------------------------------------------------------------
// Sequence: an accept step, then a step per lane taken (only the row-end check if the row
//   already ended), and a block flush when a block closes (two 29x16 partial products, row-sum add).
// A row-closing request adds its final flush and a load of the result.
// A new request is accepted only once the previous one is done, as in_stall stays high
//   meanwhile; the load waits while the result is stalled.
// Reset (synchronous, rst_n low): counters and sums cleared, row_length 32,
//   row_count 1, no result pending.
module q8_block_scaled_matvec_core #(
  parameter int BLOCK_SIZE = 32
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_wr_en,
  input  logic                                  cfg_index,
  input  logic [q8bsm_pkg::CFG_W-1:0]           cfg_data,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic signed [q8bsm_pkg::WEIGHT_W-1:0] in_weight_0,
  input  logic signed [q8bsm_pkg::WEIGHT_W-1:0] in_weight_1,
  input  logic signed [q8bsm_pkg::WEIGHT_W-1:0] in_weight_2,
  input  logic signed [q8bsm_pkg::WEIGHT_W-1:0] in_weight_3,
  input  logic signed [q8bsm_pkg::ACT_W-1:0]    in_activation_0,
  input  logic signed [q8bsm_pkg::ACT_W-1:0]    in_activation_1,
  input  logic signed [q8bsm_pkg::ACT_W-1:0]    in_activation_2,
  input  logic signed [q8bsm_pkg::ACT_W-1:0]    in_activation_3,
  input  logic signed [q8bsm_pkg::SCALE_W-1:0]  in_block_scale,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [q8bsm_pkg::RESULT_W-1:0] out_row_result,
  output logic                                  out_final_row
);

  q8bsm_pkg::cmd_t    cmd;
  q8bsm_pkg::status_t status;

  // Sequencer
  q8bsm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  // Datapath
  q8bsm_dp #(
    .BLOCK_SIZE (BLOCK_SIZE)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_weight_0     (in_weight_0),
    .in_weight_1     (in_weight_1),
    .in_weight_2     (in_weight_2),
    .in_weight_3     (in_weight_3),
    .in_activation_0 (in_activation_0),
    .in_activation_1 (in_activation_1),
    .in_activation_2 (in_activation_2),
    .in_activation_3 (in_activation_3),
    .in_block_scale  (in_block_scale),
    .cmd             (cmd),
    .status          (status),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_row_result  (out_row_result),
    .out_final_row   (out_final_row)
  );

  // An accepted request keeps the input side stalled while it is worked on
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input not stalled after accepting a request");

  // A result is never loaded over one still waiting to be taken
  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> status.out_free)
    else $error("result register overwritten");

  // No lane is accumulated once the row has ended
  a_no_step_past_end: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.lane_step |-> !status.ended)
    else $error("lane accumulated past row end");

  // At most one datapath operation per cycle
  a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.capture, cmd.lane_step, cmd.mul_lo, cmd.mul_hi,
              cmd.flush_add, cmd.emit}))
    else $error("conflicting datapath commands");

endmodule
